[rtl/core/urx_pkg.sv]
`timescale 1ns / 1ps
// Package for the UART receive ring with error counters.
// Holds function codes, clear mask bit positions and the controller command struct.
// No dependencies.
package urx_pkg;

    localparam logic [1:0] FUNC_STATUS  = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam int MASK_PARITY  = 0;
    localparam int MASK_FRAMING = 1;
    localparam int MASK_NOISE   = 2;
    localparam int MASK_OVERRUN = 3;
    localparam int MASK_BREAK   = 4;

    localparam int CNT_W  = 32;
    localparam int FILL_W = 9;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_cmd;

endpackage

[rtl/core/urx_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the UART receive ring: sequences load, execute and emit per item.
// Depends on urx_pkg for the command struct.
module urx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output urx_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec = (r_state == S_EXEC);
        o_cmd.emit = (r_state == S_DONE) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

[rtl/core/urx_dpath.sv]
`timescale 1ns / 1ps
// Datapath for the UART receive ring: byte ring memory, pointers, fill count,
// error counters and result registers. Depends on urx_pkg.
module urx_dpath #(
    parameter int RING_DEPTH = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  urx_pkg::t_cmd                i_cmd,
    input  logic [1:0]                   i_func,
    input  logic                         i_rx_ready,
    input  logic                         i_parity_flag,
    input  logic                         i_framing_flag,
    input  logic                         i_noise_flag,
    input  logic                         i_overrun_flag,
    input  logic                         i_break_flag,
    input  logic [7:0]                   i_rx_byte,
    output logic [7:0]                   o_read_byte,
    output logic                         o_read_status,
    output logic [urx_pkg::FILL_W-1:0]   o_fill_level,
    output logic [urx_pkg::CNT_W-1:0]    o_overflow_count,
    output logic [urx_pkg::CNT_W-1:0]    o_overrun_count,
    output logic [urx_pkg::CNT_W-1:0]    o_parity_count,
    output logic [urx_pkg::CNT_W-1:0]    o_framing_count,
    output logic [urx_pkg::CNT_W-1:0]    o_break_count,
    output logic [4:0]                   o_clear_mask
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = (PW > urx_pkg::FILL_W) ? PW : urx_pkg::FILL_W;
    localparam int CW = urx_pkg::CNT_W;

    logic [7:0]    r_ring [RING_DEPTH];

    logic [1:0]    r_func;
    logic          r_rx_ready;
    logic          r_par;
    logic          r_frm;
    logic          r_noi;
    logic          r_ovr;
    logic          r_brk;
    logic [7:0]    r_byte;

    logic [PW-1:0] r_rp;
    logic [PW-1:0] r_wp;
    logic [FW-1:0] r_fill;
    logic [CW-1:0] r_overflow;
    logic [CW-1:0] r_overrun;
    logic [CW-1:0] r_parity;
    logic [CW-1:0] r_framing;
    logic [CW-1:0] r_break;

    logic [7:0]    r_rd_data;
    logic          r_rd_ok;
    logic          r_rd_empty;
    logic [4:0]    r_mask;

    logic          is_status;
    logic          is_read;
    logic          store_ok;
    logic          ring_full;
    logic          ring_empty;
    logic          do_write;
    logic          do_pop;
    logic [PW-1:0] rp_next;
    logic [PW-1:0] wp_next;

    assign is_status  = (r_func == urx_pkg::FUNC_STATUS);
    assign is_read    = (r_func == urx_pkg::FUNC_READ);
    assign store_ok   = r_rx_ready && !r_par && !r_frm && !r_noi && !r_brk;
    assign ring_full  = (r_fill == FW'(RING_DEPTH - 1));
    assign ring_empty = (r_fill == '0);
    assign do_write   = i_cmd.exec && is_status && store_ok && !ring_full;
    assign do_pop     = i_cmd.exec && is_read && !ring_empty;
    assign rp_next    = (r_rp == PW'(RING_DEPTH - 1)) ? '0 : r_rp + PW'(1);
    assign wp_next    = (r_wp == PW'(RING_DEPTH - 1)) ? '0 : r_wp + PW'(1);

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_ring[r_wp] <= r_byte;
        end
        if (do_pop) begin
            r_rd_data <= r_ring[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_rx_ready <= i_rx_ready;
            r_par      <= i_parity_flag;
            r_frm      <= i_framing_flag;
            r_noi      <= i_noise_flag;
            r_ovr      <= i_overrun_flag;
            r_brk      <= i_break_flag;
            r_byte     <= i_rx_byte;
        end
        if (i_cmd.exec) begin
            r_rd_ok    <= is_read && !ring_empty;
            r_rd_empty <= is_read && ring_empty;
            if (is_status) begin
                r_mask[urx_pkg::MASK_PARITY]  <= r_par;
                r_mask[urx_pkg::MASK_FRAMING] <= r_frm;
                r_mask[urx_pkg::MASK_NOISE]   <= r_noi;
                r_mask[urx_pkg::MASK_OVERRUN] <= r_ovr;
                r_mask[urx_pkg::MASK_BREAK]   <= r_brk;
            end else begin
                r_mask <= '0;
            end
        end
        if (i_cmd.emit) begin
            o_read_byte      <= r_rd_ok ? r_rd_data : 8'd0;
            o_read_status    <= r_rd_empty;
            o_fill_level     <= r_fill[urx_pkg::FILL_W-1:0];
            o_overflow_count <= r_overflow;
            o_overrun_count  <= r_overrun;
            o_parity_count   <= r_parity;
            o_framing_count  <= r_framing;
            o_break_count    <= r_break;
            o_clear_mask     <= r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp       <= '0;
            r_wp       <= '0;
            r_fill     <= '0;
            r_overflow <= '0;
            r_overrun  <= '0;
            r_parity   <= '0;
            r_framing  <= '0;
            r_break    <= '0;
        end else if (i_cmd.exec) begin
            case (r_func)
                urx_pkg::FUNC_STATUS: begin
                    r_overrun <= r_overrun + CW'(r_ovr);
                    r_parity  <= r_parity + CW'(r_par);
                    r_framing <= r_framing + CW'(r_frm) + CW'(r_noi);
                    r_break   <= r_break + CW'(r_brk);
                    if (store_ok) begin
                        if (ring_full) begin
                            r_overflow <= r_overflow + CW'(1);
                        end else begin
                            r_wp   <= wp_next;
                            r_fill <= r_fill + FW'(1);
                        end
                    end
                end
                urx_pkg::FUNC_READ: begin
                    if (!ring_empty) begin
                        r_rp   <= rp_next;
                        r_fill <= r_fill - FW'(1);
                    end
                end
                urx_pkg::FUNC_RESTART: begin
                    r_rp       <= '0;
                    r_wp       <= '0;
                    r_fill     <= '0;
                    r_overflow <= '0;
                    r_overrun  <= '0;
                    r_parity   <= '0;
                    r_framing  <= '0;
                    r_break    <= '0;
                end
                default: begin
                    r_rp <= r_rp;
                end
            endcase
        end
    end

endmodule

[rtl/core/uart_rx_ring_with_error_counts.sv]
`timescale 1ns / 1ps
// UART receive ring with error counters: top level joining controller and datapath.
// Each item passes through the load, execute and emit states around the registered
// ring memory read; no new item is taken until the previous one has been emitted,
// and the emit state waits while a stalled result still holds the output register.
// Reset (synchronous, active low) zeroes pointers, fill and counters; the ring
// memory is not cleared, so no clearing pass runs. Depends on urx_pkg, urx_ctrl, urx_dpath.
module uart_rx_ring_with_error_counts #(
    parameter int RING_DEPTH = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_func,
    input  logic                         i_rx_ready,
    input  logic                         i_parity_flag,
    input  logic                         i_framing_flag,
    input  logic                         i_noise_flag,
    input  logic                         i_overrun_flag,
    input  logic                         i_break_flag,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_read_byte,
    output logic                         o_read_status,
    output logic [urx_pkg::FILL_W-1:0]   o_fill_level,
    output logic [urx_pkg::CNT_W-1:0]    o_overflow_count,
    output logic [urx_pkg::CNT_W-1:0]    o_overrun_count,
    output logic [urx_pkg::CNT_W-1:0]    o_parity_count,
    output logic [urx_pkg::CNT_W-1:0]    o_framing_count,
    output logic [urx_pkg::CNT_W-1:0]    o_break_count,
    output logic [4:0]                   o_clear_mask
);

    urx_pkg::t_cmd cmd;

    urx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    urx_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (i_func),
        .i_rx_ready       (i_rx_ready),
        .i_parity_flag    (i_parity_flag),
        .i_framing_flag   (i_framing_flag),
        .i_noise_flag     (i_noise_flag),
        .i_overrun_flag   (i_overrun_flag),
        .i_break_flag     (i_break_flag),
        .i_rx_byte        (i_rx_byte),
        .o_read_byte      (o_read_byte),
        .o_read_status    (o_read_status),
        .o_fill_level     (o_fill_level),
        .o_overflow_count (o_overflow_count),
        .o_overrun_count  (o_overrun_count),
        .o_parity_count   (o_parity_count),
        .o_framing_count  (o_framing_count),
        .o_break_count    (o_break_count),
        .o_clear_mask     (o_clear_mask)
    );

endmodule

[rtl/core/urx_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the UART receive ring, with its bind to the top level.
// Depends on urx_pkg and uart_rx_ring_with_error_counts.
module urx_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [7:0]                   o_read_byte,
    input logic                         o_read_status,
    input logic [urx_pkg::FILL_W-1:0]   o_fill_level,
    input logic [urx_pkg::CNT_W-1:0]    o_framing_count,
    input logic [4:0]                   o_clear_mask
);

    a_empty_read_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_status |-> o_read_byte == 8'd0 && o_clear_mask == 5'd0)
        else $error("empty read carries data or mask");

    a_empty_read_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_status |-> o_fill_level == '0)
        else $error("empty read with nonzero fill");

    a_mask_only_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clear_mask != 5'd0 |-> !o_read_status && o_read_byte == 8'd0)
        else $error("clear mask on a non-status item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_fill_level)
            && $stable(o_framing_count))
        else $error("stalled result changed");

endmodule

bind uart_rx_ring_with_error_counts urx_checker u_urx_checker (.*);
